@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the framer rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MPF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `MPF_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)
`define MPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `MPF_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)
`else
`define MPF_ASSERT(label, clk, rst_n, prop, msg)
`define MPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define MPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/mpf_pkg.sv @@
// types, codes and constants of the mqtt packet framer
// used by mpf_step and mqtt_packet_framer_top; no dependencies
`default_nettype none

package mpf_pkg;

  localparam int unsigned LEN_W   = 28;
  localparam int unsigned TOPIC_W = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [3:0] CONNECT_HEADER_BYTES   = 4'd10;
  localparam logic [3:0] SUBSCRIBE_HEADER_BYTES = 4'd2;

  localparam logic [3:0] TYPE_RESERVED_LO = 4'd0;
  localparam logic [3:0] TYPE_CONNECT     = 4'd1;
  localparam logic [3:0] TYPE_PUBLISH     = 4'd3;
  localparam logic [3:0] TYPE_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] TYPE_RESERVED_HI = 4'd15;

  // phase codes double as the byte role codes of the body phases
  typedef enum logic [2:0] {
    PH_FIRST    = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_VARHDR   = 3'd2,
    PH_TOPICLEN = 3'd3,
    PH_TOPIC    = 3'd4,
    PH_PAYLOAD  = 3'd5
  } phase_e;

  localparam logic [2:0] ROLE_FIRST  = 3'd0;
  localparam logic [2:0] ROLE_LENGTH = 3'd1;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_RESERVED_TYPE = 3'd1,
    ERR_LENGTH_BYTES  = 3'd2,
    ERR_OVER_LIMIT    = 3'd3,
    ERR_HEADER        = 3'd4
  } err_e;

  typedef struct packed {
    phase_e               phase;
    logic [3:0]           held_type;
    logic [3:0]           held_flags;
    logic [LEN_W-1:0]     len_acc;
    logic [2:0]           len_cnt;
    logic [LEN_W-1:0]     bytes_left;
    logic [3:0]           hdr_cnt;
    logic [TOPIC_W-1:0]   topic_len;
    logic [TOPIC_W-1:0]   topic_left;
  } frame_state_t;

  typedef struct packed {
    logic [7:0]           byte_out;
    logic [2:0]           role;
    logic [3:0]           packet_type;
    logic                 dup;
    logic [1:0]           qos;
    logic                 retain;
    logic [LEN_W-1:0]     rem_len;
    logic [TOPIC_W-1:0]   topic_len;
    logic                 pkt_end;
    err_e                 err;
  } frame_result_t;

  localparam frame_state_t STATE_RESET = '{
    phase:      PH_FIRST,
    held_type:  4'd0,
    held_flags: 4'd0,
    len_acc:    '0,
    len_cnt:    3'd0,
    bytes_left: '0,
    hdr_cnt:    4'd0,
    topic_len:  '0,
    topic_left: '0
  };

endpackage

`default_nettype wire

@@ rtl/core/mqtt_packet_framer_top.sv @@
// mqtt packet framer top level: handshakes, state and result registers
// depends on mpf_pkg, mpf_step and assert_macros.svh
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o | data_byte_i
//   out     | output    | out_valid_o/out_ready_i | byte_out_o .. error_code_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_max_remaining_length_i
//
// one byte per cycle unless a held result stalls input: each accepted byte
// yields one registered result, and the single frame state register feeds itself through mpf_step.
// a result waiting in the output register stalls input only when out_ready_i
// is low; then in_ready_o drops until the result is taken.
// reset clears the frame state and sets the length limit to its maximum.
// cfg writes are always taken, as cfg_ready_o is tied high.
`default_nettype none
`include "assert_macros.svh"

module mqtt_packet_framer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   byte_out_o,
  output logic [2:0]                   byte_role_o,
  output logic [3:0]                   packet_type_o,
  output logic                         dup_flag_o,
  output logic [1:0]                   qos_level_o,
  output logic                         retain_flag_o,
  output logic [mpf_pkg::LEN_W-1:0]    remaining_length_o,
  output logic [mpf_pkg::TOPIC_W-1:0]  topic_length_o,
  output logic                         packet_end_o,
  output logic [2:0]                   error_code_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mpf_pkg::LEN_W-1:0]    cfg_max_remaining_length_i
);
  import mpf_pkg::*;

  frame_state_t     state_q, state_d;
  frame_result_t    res_q, res_d;
  logic             out_valid_q;
  logic [LEN_W-1:0] max_len_q;
  logic             in_acc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  mpf_step u_step (
    .state_i     (state_q),
    .data_byte_i (data_byte_i),
    .max_len_i   (max_len_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
      max_len_q   <= LEN_MAX;
    end else begin
      if (in_acc) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_max_remaining_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign byte_out_o         = res_q.byte_out;
  assign byte_role_o        = res_q.role;
  assign packet_type_o      = res_q.packet_type;
  assign dup_flag_o         = res_q.dup;
  assign qos_level_o        = res_q.qos;
  assign retain_flag_o      = res_q.retain;
  assign remaining_length_o = res_q.rem_len;
  assign topic_length_o     = res_q.topic_len;
  assign packet_end_o       = res_q.pkt_end;
  assign error_code_o       = res_q.err;

  // any error closes the packet
  `MPF_ASSERT_IMPL(a_err_ends, clk_i, rst_ni, out_valid_o && res_q.err != ERR_NONE, packet_end_o, "error without packet end")
  // a closed packet leaves the framer waiting for a first byte
  `MPF_ASSERT_NEXT(a_end_resync, clk_i, rst_ni, in_acc && res_d.pkt_end, state_q.phase == PH_FIRST, "no resync after packet end")
  // first byte reports cleared length fields
  `MPF_ASSERT_IMPL(a_first_clear, clk_i, rst_ni, out_valid_o && byte_role_o == ROLE_FIRST, remaining_length_o == '0 && topic_length_o == '0, "stale length on first byte")
  // a held result blocks new input
  `MPF_ASSERT_IMPL(a_stall, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o, "input taken over held result")

endmodule

`default_nettype wire

@@ rtl/core/mpf_step.sv @@
// per-byte framing logic: next state and tagged result for one byte
// depends on mpf_pkg
`default_nettype none

module mpf_step (
  input  mpf_pkg::frame_state_t               state_i,
  input  logic [7:0]                          data_byte_i,
  input  logic [mpf_pkg::LEN_W-1:0]           max_len_i,
  output mpf_pkg::frame_state_t               state_o,
  output mpf_pkg::frame_result_t              result_o
);
  import mpf_pkg::*;

  frame_state_t          s;
  logic [LEN_W-1:0]      shifted;
  logic [LEN_W-1:0]      acc_new;
  logic [LEN_W-1:0]      left_dec;
  logic [3:0]            hdr_dec;
  logic [TOPIC_W-1:0]    topic_dec;
  logic [TOPIC_W-1:0]    tl_full;
  logic [3:0]            need;
  logic [2:0]            role;
  err_e                  err;
  logic                  pkt_end;
  logic                  pub;

  // seven bit groups, low group first
  always_comb begin
    unique case (state_i.len_cnt[1:0])
      2'd0:    shifted = {21'd0, data_byte_i[6:0]};
      2'd1:    shifted = {14'd0, data_byte_i[6:0], 7'd0};
      2'd2:    shifted = {7'd0, data_byte_i[6:0], 14'd0};
      default: shifted = {data_byte_i[6:0], 21'd0};
    endcase
  end

  assign acc_new   = state_i.len_acc | shifted;
  assign left_dec  = (state_i.bytes_left != '0) ? state_i.bytes_left - LEN_W'(1)
                                                : state_i.bytes_left;
  assign hdr_dec   = (state_i.hdr_cnt != 4'd0) ? state_i.hdr_cnt - 4'd1 : state_i.hdr_cnt;
  assign topic_dec = (state_i.topic_left != '0) ? state_i.topic_left - TOPIC_W'(1)
                                                : state_i.topic_left;
  assign tl_full   = state_i.topic_len | {8'h00, data_byte_i};
  assign need      = (state_i.held_type == TYPE_CONNECT) ? CONNECT_HEADER_BYTES
                                                         : SUBSCRIBE_HEADER_BYTES;

  always_comb begin
    s       = state_i;
    role    = ROLE_FIRST;
    err     = ERR_NONE;
    pkt_end = 1'b0;
    unique case (state_i.phase)
      PH_LENGTH: begin
        role = ROLE_LENGTH;
        if (state_i.len_cnt[2]) begin
          err     = ERR_LENGTH_BYTES;
          pkt_end = 1'b1;
          s.phase = PH_FIRST;
        end else begin
          s.len_acc = acc_new;
          s.len_cnt = state_i.len_cnt + 3'd1;
          if (!data_byte_i[7]) begin
            // length field complete
            if (acc_new > max_len_i) begin
              err     = ERR_OVER_LIMIT;
              pkt_end = 1'b1;
              s.phase = PH_FIRST;
            end else begin
              s.bytes_left = acc_new;
              if (acc_new == '0) begin
                pkt_end = 1'b1;
                s.phase = PH_FIRST;
              end else if (state_i.held_type == TYPE_PUBLISH) begin
                if (acc_new < LEN_W'(2)) begin
                  err     = ERR_HEADER;
                  pkt_end = 1'b1;
                  s.phase = PH_FIRST;
                end else begin
                  s.hdr_cnt = 4'd2;
                  s.phase   = PH_TOPICLEN;
                end
              end else if (state_i.held_type == TYPE_CONNECT ||
                           state_i.held_type == TYPE_SUBSCRIBE) begin
                if (LEN_W'(need) > acc_new) begin
                  err     = ERR_HEADER;
                  pkt_end = 1'b1;
                  s.phase = PH_FIRST;
                end else begin
                  s.hdr_cnt = need;
                  s.phase   = (need == 4'd0) ? PH_PAYLOAD : PH_VARHDR;
                end
              end else begin
                s.phase = PH_PAYLOAD;
              end
            end
          end
        end
      end
      PH_VARHDR: begin
        role         = 3'(state_i.phase);
        s.bytes_left = left_dec;
        s.hdr_cnt    = hdr_dec;
        if (left_dec == '0) begin
          pkt_end = 1'b1;
          s.phase = PH_FIRST;
        end else if (hdr_dec == 4'd0) begin
          s.phase = PH_PAYLOAD;
        end
      end
      PH_TOPICLEN: begin
        role         = 3'(state_i.phase);
        s.bytes_left = left_dec;
        if (state_i.hdr_cnt != 4'd1) begin
          s.topic_len = {data_byte_i, 8'h00};
          s.hdr_cnt   = 4'd1;
        end else begin
          s.topic_len = tl_full;
          s.hdr_cnt   = 4'd0;
          if (LEN_W'(tl_full) > left_dec) begin
            err     = ERR_HEADER;
            pkt_end = 1'b1;
            s.phase = PH_FIRST;
          end else begin
            s.topic_left = tl_full;
            if (left_dec == '0) begin
              pkt_end = 1'b1;
              s.phase = PH_FIRST;
            end else begin
              s.phase = (tl_full == '0) ? PH_PAYLOAD : PH_TOPIC;
            end
          end
        end
      end
      PH_TOPIC: begin
        role         = 3'(state_i.phase);
        s.bytes_left = left_dec;
        s.topic_left = topic_dec;
        if (left_dec == '0) begin
          pkt_end = 1'b1;
          s.phase = PH_FIRST;
        end else if (topic_dec == '0) begin
          s.phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        role         = 3'(state_i.phase);
        s.bytes_left = left_dec;
        if (left_dec == '0) begin
          pkt_end = 1'b1;
          s.phase = PH_FIRST;
        end
      end
      default: begin
        // first byte of a packet, also taken after any error
        s            = STATE_RESET;
        s.held_type  = data_byte_i[7:4];
        s.held_flags = data_byte_i[3:0];
        if (data_byte_i[7:4] == TYPE_RESERVED_LO ||
            data_byte_i[7:4] == TYPE_RESERVED_HI) begin
          err     = ERR_RESERVED_TYPE;
          pkt_end = 1'b1;
          s.phase = PH_FIRST;
        end else begin
          s.phase = PH_LENGTH;
        end
      end
    endcase
  end

  assign pub = (s.held_type == TYPE_PUBLISH);

  always_comb begin
    result_o.byte_out    = data_byte_i;
    result_o.role        = role;
    result_o.packet_type = s.held_type;
    result_o.dup         = pub & s.held_flags[3];
    result_o.qos         = pub ? s.held_flags[2:1] : 2'd0;
    result_o.retain      = pub & s.held_flags[0];
    result_o.rem_len     = s.len_acc;
    result_o.topic_len   = s.topic_len;
    result_o.pkt_end     = pkt_end;
    result_o.err         = err;
  end

  assign state_o = s;

endmodule

`default_nettype wire
